// ===== design/bcc_pkg.sv =====
// ----------------------------------------------------------------------------
// bcc_pkg: shared types and constants for the button click classifier
// Request codes, event codes, register indexes and configuration bundle.
// ----------------------------------------------------------------------------
package bcc_pkg;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CHATTER_W = 16;
  localparam int unsigned WINDOW_W  = 10;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic {
    REQ_EDGE = 1'b0,
    REQ_TICK = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_LONG   = 2'd1,
    EV_DOUBLE = 2'd2
  } ev_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHATTER = 1'b0,
    CFG_WINDOW  = 1'b1
  } cfg_idx_t;

  localparam logic [CHATTER_W-1:0] CHATTER_RST = 16'd5000;
  localparam logic [WINDOW_W-1:0]  WINDOW_RST  = 10'd500;

  localparam logic [COUNT_W-1:0] LONG_EDGES       = 8'd1;
  localparam logic [COUNT_W-1:0] DOUBLE_MIN_EDGES = 8'd3;
  localparam logic [COUNT_W-1:0] COUNT_MAX        = 8'd255;

  typedef struct packed {
    logic [CHATTER_W-1:0] chatter_delay_us;
    logic [WINDOW_W-1:0]  window_ms;
  } cfg_t;

endpackage

// ===== design/bcc_if.sv =====
// ----------------------------------------------------------------------------
// bcc_if: valid/ready channels of the button click classifier
// Request channel (edge or tick) and result channel (click event).
// ----------------------------------------------------------------------------
interface bcc_req_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic [bcc_pkg::TIME_W-1:0]        edge_time_us;

  modport source (output valid, output req_type, output edge_time_us, input ready);
  modport sink   (input valid, input req_type, input edge_time_us, output ready);
endinterface

interface bcc_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] click_event;

  modport source (output valid, output click_event, input ready);
  modport sink   (input valid, input click_event, output ready);
endinterface

// ===== design/button_click_classifier.sv =====
// ----------------------------------------------------------------------------
// button_click_classifier: debounced long press / double click detector
//
//   channel  | dir | transaction payload
//   ---------+-----+-------------------------------------------
//   req      | in  | req_type, edge_time_us
//   rsp      | out | click_event (one per request)
//   cfg      | in  | cfg_we, cfg_index, cfg_data (write only)
//
// One request per cycle while the request side is not stalled; the input register
// loads at acceptance and the result register loads from it, after the single state-update pass.
// Synchronous reset restores registers to 5000 us / 500 ms and clears state.
// A stalled result holds in its register while the input register still takes
// one more request; the request side stalls only when both are full.
// ----------------------------------------------------------------------------
module button_click_classifier (
  input  logic                                clk,
  input  logic                                rst,
  bcc_req_if.sink                             req,
  bcc_rsp_if.source                           rsp,
  input  logic                                cfg_we,
  input  logic [bcc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bcc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  bcc_pkg::cfg_t               cfg;
  logic                        s1_valid;
  logic                        s1_req_type;
  logic [bcc_pkg::TIME_W-1:0]  s1_edge_time_us;
  logic                        rsp_valid;
  bcc_pkg::ev_t                rsp_event;
  bcc_pkg::ev_t                ev;
  logic                        rsp_load;
  logic                        s1_fire;

  assign rsp_load  = !rsp_valid || rsp.ready;
  assign s1_fire   = s1_valid && rsp_load;
  assign req.ready = !s1_valid || rsp_load;

  assign rsp.valid       = rsp_valid;
  assign rsp.click_event = rsp_event;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.chatter_delay_us <= bcc_pkg::CHATTER_RST;
      cfg.window_ms        <= bcc_pkg::WINDOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bcc_pkg::CFG_CHATTER: cfg.chatter_delay_us <= cfg_data;
        bcc_pkg::CFG_WINDOW:  cfg.window_ms <= cfg_data[bcc_pkg::WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s1_req_type     <= req.req_type;
      s1_edge_time_us <= req.edge_time_us;
    end
  end

  bcc_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .fire         (s1_fire),
    .req_type     (s1_req_type),
    .edge_time_us (s1_edge_time_us),
    .ev           (ev)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      rsp_event <= ev;
    end
  end

endmodule

// ===== design/bcc_core.sv =====
// ----------------------------------------------------------------------------
// bcc_core: button state and click classification
// Holds the level, edge count and window counter; updates them for one
// request per cycle and produces the event for that request.
// ----------------------------------------------------------------------------
module bcc_core (
  input  logic                         clk,
  input  logic                         rst,
  input  bcc_pkg::cfg_t                cfg,
  input  logic                         fire,
  input  logic                         req_type,
  input  logic [bcc_pkg::TIME_W-1:0]   edge_time_us,
  output bcc_pkg::ev_t                 ev
);

  logic                           pressed_level, pressed_level_next;
  logic [bcc_pkg::COUNT_W-1:0]    edge_count, edge_count_next;
  logic [bcc_pkg::WINDOW_W-1:0]   ms_count, ms_count_next;
  logic                           long_held, long_held_next;
  logic [bcc_pkg::TIME_W-1:0]     last_edge_time, last_edge_time_next;
  logic                           edge_seen, edge_seen_next;

  logic [bcc_pkg::TIME_W-1:0]     elapsed;
  logic [bcc_pkg::WINDOW_W:0]     ms_inc;

  assign elapsed = edge_time_us - last_edge_time;
  assign ms_inc  = {1'b0, ms_count} + {{bcc_pkg::WINDOW_W{1'b0}}, 1'b1};

  always_comb begin
    pressed_level_next  = pressed_level;
    edge_count_next     = edge_count;
    ms_count_next       = ms_count;
    long_held_next      = long_held;
    last_edge_time_next = last_edge_time;
    edge_seen_next      = edge_seen;
    ev                  = bcc_pkg::EV_NONE;
    if (fire) begin
      if (req_type == bcc_pkg::REQ_EDGE) begin
        pressed_level_next = ~pressed_level;
        // elapsed time wraps modulo 2^32
        if (!edge_seen ||
            elapsed >= {{(bcc_pkg::TIME_W-bcc_pkg::CHATTER_W){1'b0}},
                        cfg.chatter_delay_us}) begin
          edge_seen_next      = 1'b1;
          last_edge_time_next = edge_time_us;
          if (edge_count != bcc_pkg::COUNT_MAX) begin
            edge_count_next = edge_count + 8'd1;
          end
        end
      end else if (ms_inc >= {1'b0, cfg.window_ms}) begin
        // window closes
        ms_count_next = '0;
        if (edge_count == bcc_pkg::LONG_EDGES && pressed_level) begin
          long_held_next = 1'b1;
          ev             = bcc_pkg::EV_LONG;
        end else if (edge_count != '0) begin
          edge_count_next = '0;
          long_held_next  = 1'b0;
        end
      end else begin
        ms_count_next = ms_inc[bcc_pkg::WINDOW_W-1:0];
        if (long_held && pressed_level) begin
          ev = bcc_pkg::EV_LONG;
        end else begin
          if (long_held) begin
            long_held_next = 1'b0;
          end
          if (edge_count > bcc_pkg::DOUBLE_MIN_EDGES) begin
            edge_count_next = '0;
            long_held_next  = 1'b0;
            ev              = bcc_pkg::EV_DOUBLE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pressed_level  <= 1'b0;
      edge_count     <= '0;
      ms_count       <= '0;
      long_held      <= 1'b0;
      last_edge_time <= '0;
      edge_seen      <= 1'b0;
    end else begin
      pressed_level  <= pressed_level_next;
      edge_count     <= edge_count_next;
      ms_count       <= ms_count_next;
      long_held      <= long_held_next;
      last_edge_time <= last_edge_time_next;
      edge_seen      <= edge_seen_next;
    end
  end

endmodule

// ===== test/bcc_checker.sv =====
// ----------------------------------------------------------------------------
// bcc_checker: click event predictor and scoreboard
// Watches the request, result and register write ports of the button click
// classifier, keeps its own copy of the debounce and window state, and
// compares every result transaction with the oldest predicted click event.
// ----------------------------------------------------------------------------
module bcc_checker
  import bcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  bcc_req_if                    req,
  bcc_rsp_if                    rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    outstanding
);

  logic [CHATTER_W-1:0] chatter;
  logic [WINDOW_W-1:0]  window;

  logic                 level;
  logic [COUNT_W-1:0]   clicks;
  logic [WINDOW_W-1:0]  ms;
  logic                 holding;
  logic [TIME_W-1:0]    last_stamp;
  logic                 seen;

  ev_t expected_events[$];

  task automatic report_mismatch(input string msg);
    // keep the log short, count everything
    if (errors < 40) $display("%0t checker: %s", $time, msg);
    errors++;
  endtask

  function automatic ev_t classify_step(input req_t kind, input logic [TIME_W-1:0] stamp);
    logic [TIME_W-1:0]   elapsed;
    logic [WINDOW_W:0]   next_ms;
    if (kind == REQ_EDGE) begin
      level = !level;
      elapsed = stamp - last_stamp;
      if (!seen || elapsed >= TIME_W'(chatter)) begin
        seen = 1'b1;
        last_stamp = stamp;
        if (clicks != COUNT_MAX) clicks = clicks + 1'b1;
      end
      return EV_NONE;
    end
    next_ms = {1'b0, ms} + 1'b1;
    if (next_ms >= {1'b0, window}) begin
      // window closes: single held edge is a long press, else drop the count
      ms = '0;
      if (clicks == LONG_EDGES && level) begin
        holding = 1'b1;
        return EV_LONG;
      end
      if (clicks != '0) begin
        clicks = '0;
        holding = 1'b0;
      end
      return EV_NONE;
    end
    ms = next_ms[WINDOW_W-1:0];
    if (holding) begin
      if (level) return EV_LONG;
      holding = 1'b0;
    end
    if (clicks > DOUBLE_MIN_EDGES) begin
      clicks = '0;
      holding = 1'b0;
      return EV_DOUBLE;
    end
    return EV_NONE;
  endfunction

  always @(posedge clk) begin : track
    ev_t want;
    if (rst) begin
      chatter = CHATTER_RST;
      window = WINDOW_RST;
      level = 1'b0;
      clicks = '0;
      ms = '0;
      holding = 1'b0;
      last_stamp = '0;
      seen = 1'b0;
      expected_events.delete();
      errors = 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_CHATTER: chatter = cfg_data[CHATTER_W-1:0];
          CFG_WINDOW:  window = cfg_data[WINDOW_W-1:0];
          default: ;
        endcase
      end
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("click_event %0d with no request pending",
                                    rsp.click_event));
        end else begin
          want = expected_events.pop_front();
          if (rsp.click_event !== want)
            report_mismatch($sformatf("click_event %0d, expected %0d (%s)",
                                      rsp.click_event, want, want.name()));
        end
      end
      if (req.valid === 1'b1 && req.ready === 1'b1)
        expected_events.push_back(classify_step(req_t'(req.req_type), req.edge_time_us));
      // registered so the stimulus side never races this block
      outstanding <= expected_events.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: button click classifier
// Drives edge and tick transactions in bursts against a randomly stalling
// result port, covering timestamp wrap, chatter rejection, count saturation,
// long press, double click and odd window settings; bcc_checker scores.
// ----------------------------------------------------------------------------
module testbench;
  import bcc_pkg::*;

  typedef struct packed {
    req_t              kind;
    logic [TIME_W-1:0] stamp;
  } btn_item_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    errors;
  int                    outstanding;

  bcc_req_if req_ch ();
  bcc_rsp_if rsp_ch ();

  button_click_classifier u_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bcc_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  btn_item_t         press_script[$];
  logic [TIME_W-1:0] now_us;
  bit                level;
  int unsigned       cur_chatter;
  int unsigned       cur_window;
  bit                hold_off;
  bit                held;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic queue_item(input req_t kind, input logic [TIME_W-1:0] stamp);
    btn_item_t it;
    it.kind = kind;
    it.stamp = stamp;
    press_script.push_back(it);
    if (kind == REQ_EDGE) level = !level;
  endtask

  // counted edges clear the chatter delay, bounces stay well inside a nonzero one
  task automatic add_edge(input bit counted);
    if (counted)
      now_us = now_us + cur_chatter + $urandom_range(0, 300);
    else if (cur_chatter > 3)
      now_us = now_us + $urandom_range(0, cur_chatter / 4);
    queue_item(REQ_EDGE, now_us);
  endtask

  task automatic add_tick();
    now_us = now_us + 1000;
    queue_item(REQ_TICK, $urandom);
  endtask

  task automatic add_gesture();
    int unsigned span;
    span = (cur_window > 40) ? 40 : cur_window;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        repeat ($urandom_range(4, 6)) begin
          add_edge(1'b1);
          repeat ($urandom_range(0, 2)) add_edge(1'b0);
          if ($urandom_range(0, 3) == 0) add_tick();
        end
        repeat ($urandom_range(1, 3)) add_tick();
      end
      4, 5, 6: begin
        // long press needs a quiet window first so the press is the only count
        if (level) add_edge(1'b1);
        repeat (span + 1) add_tick();
        add_edge(1'b1);
        repeat ($urandom_range(0, 1)) add_edge(1'b0);
        repeat (span + $urandom_range(0, 4)) add_tick();
        add_edge(1'b1);
        repeat ($urandom_range(1, 3)) add_tick();
      end
      7: begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 1) == 0) queue_item(REQ_EDGE, $urandom);
          else add_tick();
        end
      end
      default: begin
        repeat ($urandom_range(1, 10)) add_tick();
      end
    endcase
  endtask

  task automatic play_script();
    btn_item_t   it;
    int unsigned burst;
    int unsigned gap;
    burst = 0;
    while (press_script.size() != 0) begin
      it = press_script.pop_front();
      if (burst == 0) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (hold_off && !held) gap = 0;
        if (gap != 0) begin
          req_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst = $urandom_range(1, 24);
      end
      req_ch.valid <= 1'b1;
      req_ch.req_type <= it.kind;
      req_ch.edge_time_us <= it.stamp;
      @(posedge clk);
      while (!req_ch.ready) @(posedge clk);
      burst--;
    end
    req_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input int unsigned chatter, input int unsigned window);
    logic [CFG_DATA_W-1:0] wdata;
    cur_chatter = chatter;
    cur_window = window;
    wdata = CFG_DATA_W'($urandom);
    wdata[WINDOW_W-1:0] = WINDOW_W'(window);
    cfg_we <= 1'b1;
    cfg_index <= CFG_CHATTER;
    cfg_data <= CFG_DATA_W'(chatter);
    @(posedge clk);
    cfg_index <= CFG_WINDOW;
    cfg_data <= wdata;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // result side: own stall pattern plus one long hold-off on request
  initial begin : receiver
    rsp_ch.ready <= 1'b0;
    held = 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (hold_off && !held) begin
        rsp_ch.ready <= 1'b0;
        repeat (80) @(posedge clk);
        held = 1'b1;
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(20, 60)) @(posedge clk);
          end
          1: begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
          end
          default: begin
            rsp_ch.ready <= 1'($urandom_range(0, 1));
            @(posedge clk);
          end
        endcase
      end
    end
  end

  initial begin : stimulus
    int unsigned made;
    int unsigned ch;
    int unsigned win;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_CHATTER;
    cfg_data <= '0;
    req_ch.valid <= 1'b0;
    req_ch.req_type <= REQ_EDGE;
    req_ch.edge_time_us <= '0;
    hold_off = 1'b0;
    level = 1'b0;
    made = 0;
    cur_chatter = CHATTER_RST;
    cur_window = WINDOW_RST;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: first edge, wrap both ways, chatter boundary, double click
    queue_item(REQ_EDGE, 32'h0000_0000);
    queue_item(REQ_EDGE, 32'hFFFF_FFFF);
    queue_item(REQ_EDGE, 32'h0000_0064);
    queue_item(REQ_EDGE, 32'h8000_0000);
    queue_item(REQ_EDGE, 32'h8000_1387);
    queue_item(REQ_EDGE, 32'h8000_1388);
    add_tick();
    add_tick();
    play_script();
    drain();

    // zero chatter, short window: long press, repeat, release inside window
    program_regs(0, 3);
    now_us = 32'h1234_0000;
    queue_item(REQ_EDGE, now_us);
    add_tick();
    add_tick();
    queue_item(REQ_EDGE, now_us);
    add_tick();
    add_tick();
    play_script();
    drain();

    // window of zero classifies on every tick
    program_regs(65535, 0);
    add_tick();
    add_tick();
    queue_item(REQ_EDGE, $urandom);
    add_tick();
    play_script();
    drain();

    // window lowered below the running count closes at the next tick
    program_regs(1000, 20);
    repeat (4) add_tick();
    play_script();
    drain();
    program_regs(1000, 2);
    add_tick();
    play_script();
    drain();

    now_us = $urandom;
    for (int ph = 0; made < 1000 || ph < 6; ph++) begin
      case (ph)
        0: program_regs(65535, 1023);
        1: program_regs(0, 1);
        2: program_regs(0, 6);
        default: begin
          case ($urandom_range(0, 7))
            0:       ch = 0;
            1:       ch = 65535;
            default: ch = $urandom_range(1, 3000);
          endcase
          case ($urandom_range(0, 9))
            0:       win = 0;
            1:       win = 1;
            default: win = $urandom_range(2, 40);
          endcase
          program_regs(ch, win);
        end
      endcase
      if (ph == 2) begin
        // saturate the edge count, then a tick inside the window
        repeat (255 + $urandom_range(1, 4)) add_edge(1'b1);
        add_tick();
      end
      if (ph == 3) hold_off = 1'b1;
      while (press_script.size() < 110) add_gesture();
      made += press_script.size();
      play_script();
      drain();
    end

    repeat (6) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
